// File: rtl/core/urlpd_pkg.sv
// Shared types and character constants for the URL percent decoder.
`default_nettype none
package urlpd_pkg;

  // Characters that take part in the escape match
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_TWO  = 8'h32;
  localparam logic [7:0] CH_FOUR = 8'h34;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_AT   = 8'h40;

  // Distance from a digit to the character it decodes to
  localparam logic [7:0] DIGIT_OFS  = 8'h10;  // '0'..'7' -> 0x20..0x27
  localparam logic [7:0] LETTER_OFS = 8'h17;  // 'A'..'E' -> 0x2A..0x2E

  // Most result items one input item can cause
  localparam int unsigned MAX_RES = 3;

  // Escape prefix held between items
  typedef enum logic [3:0] {
    PEND_NONE = 4'b0001,
    PEND_PCT  = 4'b0010,
    PEND_TWO  = 4'b0100,
    PEND_FOUR = 4'b1000
  } pend_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // Decode result of one input item, handed to the output buffer
  typedef struct packed {
    out_item_t [MAX_RES-1:0] items;
    logic [1:0]              cnt;
    pend_t                   pend_next;
  } dec_t;

endpackage
`default_nettype wire

// File: rtl/core/urlpd_decode.sv
// Combinational escape decode of one registered input item.
`default_nettype none
module urlpd_decode (
  input  wire urlpd_pkg::in_item_t item,
  input  wire urlpd_pkg::pend_t    pend,
  output urlpd_pkg::dec_t          dec
);
  import urlpd_pkg::*;

  logic [7:0] b;
  logic [1:0] n;
  pend_t      pn;
  out_item_t [MAX_RES-1:0] res;

  assign b = item.in_byte;

  // Build the result list in order, one slot per emitted byte
  always_comb begin
    res = '0;
    n   = 2'd0;
    pn  = PEND_NONE;
    case (pend)
      PEND_PCT: begin
        if (b == CH_TWO) begin
          pn = PEND_TWO;
        end else if (b == CH_FOUR) begin
          pn = PEND_FOUR;
        end else begin
          res[n].out_byte = CH_PCT;
          n = n + 2'd1;
          if (b == CH_PCT) begin
            pn = PEND_PCT;
          end else begin
            res[n].out_byte = b;
            n = n + 2'd1;
          end
        end
      end
      PEND_TWO: begin
        if (b >= CH_ZERO && b <= CH_SEVEN) begin
          res[n].out_byte = b - DIGIT_OFS;
          n = n + 2'd1;
        end else if (b >= CH_A && b <= CH_E) begin
          res[n].out_byte = b - LETTER_OFS;
          n = n + 2'd1;
        end else begin
          res[n].out_byte = CH_PCT;
          n = n + 2'd1;
          res[n].out_byte = CH_TWO;
          n = n + 2'd1;
          if (b == CH_PCT) begin
            pn = PEND_PCT;
          end else begin
            res[n].out_byte = b;
            n = n + 2'd1;
          end
        end
      end
      PEND_FOUR: begin
        if (b == CH_ZERO) begin
          res[n].out_byte = CH_AT;
          n = n + 2'd1;
        end else begin
          res[n].out_byte = CH_PCT;
          n = n + 2'd1;
          res[n].out_byte = CH_FOUR;
          n = n + 2'd1;
          if (b == CH_PCT) begin
            pn = PEND_PCT;
          end else begin
            res[n].out_byte = b;
            n = n + 2'd1;
          end
        end
      end
      default: begin
        if (b == CH_PCT) begin
          pn = PEND_PCT;
        end else begin
          res[n].out_byte = b;
          n = n + 2'd1;
        end
      end
    endcase

    // Final byte flushes any held prefix and tags the last result
    if (item.in_last) begin
      if (pn != PEND_NONE) begin
        res[n].out_byte = CH_PCT;
        n = n + 2'd1;
        if (pn == PEND_TWO) begin
          res[n].out_byte = CH_TWO;
          n = n + 2'd1;
        end else if (pn == PEND_FOUR) begin
          res[n].out_byte = CH_FOUR;
          n = n + 2'd1;
        end
      end
      pn = PEND_NONE;
      if (n != 2'd0) begin
        res[n - 2'd1].out_last = 1'b1;
      end
    end
  end

  assign dec.items     = res;
  assign dec.cnt       = n;
  assign dec.pend_next = pn;

endmodule
`default_nettype wire

// File: rtl/core/urlpd_out_buf.sv
// Result buffer: holds the bytes of one decoded item and sends one per cycle while out_stall is low.
`default_nettype none
module urlpd_out_buf (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   load,
  input  wire urlpd_pkg::dec_t  dec,
  output logic                  can_load,
  output logic                  out_valid,
  input  wire                   out_stall,
  output urlpd_pkg::out_item_t  out_item
);
  import urlpd_pkg::*;

  out_item_t  ent [MAX_RES];
  logic [1:0] cnt;
  logic       pop;

  assign out_valid = (cnt != 2'd0);
  assign out_item  = ent[0];
  assign pop       = out_valid && !out_stall;

  // Room for a new set once the buffer is empty or drains this cycle
  assign can_load = (cnt == 2'd0) || (cnt == 2'd1 && pop);

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= dec.cnt;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Entries: load a whole set, or shift toward the head on a send
  always_ff @(posedge clk) begin
    if (load) begin
      ent[0] <= dec.items[0];
      ent[1] <= dec.items[1];
      ent[2] <= dec.items[2];
    end else if (pop) begin
      ent[0] <= ent[1];
      ent[1] <= ent[2];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/url_percent_decoder.sv
// Top level of the URL percent decoder: input register, prefix state, decode, result buffer.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in      | sink      | in_valid / in_stall   | in_item  (in_byte, in_last)
//   out     | source    | out_valid / out_stall | out_item (out_byte, out_last)
//
// An accepted item waits in the input register until the result buffer can take it,
// then decodes into the buffer, from which its first result is sent.
// An item causing zero or one result keeps the rate at one item per cycle while out_stall is low;
// one causing more results holds the next item in the input register until the buffer sends its last result.
// Synchronous reset empties both registers and clears the held prefix.
// out_stall reaches in_stall combinationally through the buffer's load check.
`default_nettype none
module url_percent_decoder (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire urlpd_pkg::in_item_t in_item,
  output logic                  out_valid,
  input  wire                   out_stall,
  output urlpd_pkg::out_item_t  out_item
);
  import urlpd_pkg::*;

  in_item_t in_r;
  logic     in_valid_r;
  pend_t    pend;
  dec_t     dec;
  logic     can_load;
  logic     load;

  assign load     = in_valid_r && can_load;
  assign in_stall = in_valid_r && !load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (load) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_item;
    end
  end

  // Held escape prefix advances when an item moves into the buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= PEND_NONE;
    end else if (load) begin
      pend <= dec.pend_next;
    end
  end

  urlpd_decode u_decode (
    .item (in_r),
    .pend (pend),
    .dec  (dec)
  );

  urlpd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .dec       (dec),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // A final byte always yields at least one result
  a_last_has_result: assert property (@(posedge clk) disable iff (rst)
    load && in_r.in_last |-> dec.cnt != 2'd0)
    else $error("final item decoded to no result");

  // A final byte leaves no prefix behind
  a_last_clears_pend: assert property (@(posedge clk) disable iff (rst)
    load && in_r.in_last |=> pend == PEND_NONE)
    else $error("prefix still held after final item");

  // An empty buffer never holds back a waiting item
  a_empty_takes_item: assert property (@(posedge clk) disable iff (rst)
    !out_valid && in_valid_r |-> !in_stall)
    else $error("input stalled while result buffer empty");

endmodule
`default_nettype wire

// File: tb/sv/tb_url_percent_decoder.sv
// Self-checking testbench for the URL percent decoder: directed table, then random escapes.
`timescale 1ns / 1ps
module tb_url_percent_decoder;
  import urlpd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RAND_ITEMS  = 280;
  localparam int N_DIR       = 27;

  typedef out_item_t char_q_t[$];

  // Directed row: raw item and, where n_fixed >= 0, its results typed in
  // (first result byte in fixed[23:16]; out_last on the final one if in_last)
  typedef struct {
    in_item_t    item;
    int          n_fixed;
    logic [23:0] fixed;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        n_fail         = 0;
  int        n_sent         = 0;
  int        cycle_cnt      = 0;

  // Predictor copy of the held escape prefix, and decoded chars still due
  pend_t     held_prefix    = PEND_NONE;
  out_item_t due_chars[$];

  dir_row_t dir_rows [N_DIR] = '{
    '{{8'h00,   1'b0},  1, 24'h00_0000},  // zero byte is a plain literal
    '{{8'hFF,   1'b1},  1, 24'hFF_0000},  // top byte, ends a URL
    '{{CH_PCT,  1'b0},  0, 24'h00_0000},
    '{{CH_TWO,  1'b0},  0, 24'h00_0000},
    '{{CH_ZERO, 1'b0},  1, 24'h20_0000},  // %20
    '{{CH_PCT,  1'b0}, -1, '0},
    '{{CH_TWO,  1'b0}, -1, '0},
    '{{CH_SEVEN, 1'b0}, -1, '0},          // %27, top digit
    '{{CH_PCT,  1'b0}, -1, '0},
    '{{CH_TWO,  1'b0}, -1, '0},
    '{{CH_E,    1'b0}, -1, '0},           // %2E, top letter
    '{{CH_PCT,  1'b0}, -1, '0},
    '{{CH_FOUR, 1'b0}, -1, '0},
    '{{CH_ZERO, 1'b0},  1, 24'h40_0000},  // %40
    '{{CH_PCT,  1'b0}, -1, '0},
    '{{CH_PCT,  1'b0},  1, 24'h25_0000},  // second % restarts the match
    '{{CH_TWO,  1'b0}, -1, '0},
    '{{8'h38,   1'b0},  3, 24'h25_3238},  // %28 is not decoded
    '{{CH_PCT,  1'b0}, -1, '0},
    '{{CH_FOUR, 1'b0}, -1, '0},
    '{{8'h61,   1'b1},  3, 24'h25_3461},  // lower case fails, ends a URL
    '{{CH_PCT,  1'b0}, -1, '0},
    '{{CH_TWO,  1'b1},  2, 24'h25_3200},  // %2 flushed at the end
    '{{CH_PCT,  1'b1},  1, 24'h25_0000},  // lone % flushed at the end
    '{{CH_PCT,  1'b0}, -1, '0},
    '{{CH_FOUR, 1'b0}, -1, '0},
    '{{CH_PCT,  1'b1},  3, 24'h25_3425}   // %4 fails on %, which is flushed
  };

  url_percent_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Random receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Decode one raw char against the held prefix; returns the chars it releases
  function automatic char_q_t decode_char(in_item_t it);
    char_q_t    r;
    logic [7:0] b;
    logic [7:0] c;
    pend_t      was;
    bit         retry;
    out_item_t  tail;
    b           = it.in_byte;
    was         = held_prefix;
    held_prefix = PEND_NONE;
    retry       = 1'b0;
    case (was)
      PEND_PCT: begin
        if (b == CH_TWO) held_prefix = PEND_TWO;
        else if (b == CH_FOUR) held_prefix = PEND_FOUR;
        else begin
          r.push_back(out_item_t'({CH_PCT, 1'b0}));
          retry = 1'b1;
        end
      end
      PEND_TWO: begin
        if (b >= CH_ZERO && b <= CH_SEVEN) begin
          c = 8'h20 + (b - CH_ZERO);
          r.push_back(out_item_t'({c, 1'b0}));
        end else if (b >= CH_A && b <= CH_E) begin
          c = 8'h2A + (b - CH_A);
          r.push_back(out_item_t'({c, 1'b0}));
        end else begin
          r.push_back(out_item_t'({CH_PCT, 1'b0}));
          r.push_back(out_item_t'({CH_TWO, 1'b0}));
          retry = 1'b1;
        end
      end
      PEND_FOUR: begin
        if (b == CH_ZERO) r.push_back(out_item_t'({CH_AT, 1'b0}));
        else begin
          r.push_back(out_item_t'({CH_PCT, 1'b0}));
          r.push_back(out_item_t'({CH_FOUR, 1'b0}));
          retry = 1'b1;
        end
      end
      default: retry = 1'b1;
    endcase
    // Failed or no prefix: look at the char from scratch
    if (retry) begin
      if (b == CH_PCT) held_prefix = PEND_PCT;
      else r.push_back(out_item_t'({b, 1'b0}));
    end
    // End of URL flushes the prefix and marks the final char
    if (it.in_last) begin
      if (held_prefix != PEND_NONE) r.push_back(out_item_t'({CH_PCT, 1'b0}));
      if (held_prefix == PEND_TWO) r.push_back(out_item_t'({CH_TWO, 1'b0}));
      else if (held_prefix == PEND_FOUR) r.push_back(out_item_t'({CH_FOUR, 1'b0}));
      held_prefix = PEND_NONE;
      if (r.size() > 0) begin
        tail = r.pop_back();
        tail.out_last = 1'b1;
        r.push_back(tail);
      end
    end
    return r;
  endfunction

  // Offer one item, wait for it to be taken, then queue what it must produce
  task automatic send_char(input in_item_t it, input int n_fixed, input logic [23:0] fixed);
    char_q_t got;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_item  <= in_item_t'($urandom_range(511));
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < send_idle_pct);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    n_sent++;
    got = decode_char(it);
    if (n_fixed < 0) begin
      foreach (got[k]) due_chars.push_back(got[k]);
    end else begin
      for (int k = 0; k < n_fixed; k++) begin
        due_chars.push_back(out_item_t'({fixed[23-8*k -: 8], it.in_last && k == n_fixed - 1}));
      end
    end
  endtask

  // Half well-formed escapes with random content; the rest broken ones and noise
  task automatic send_fragment();
    logic [7:0] frag[$];
    int         pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      frag.push_back(CH_PCT);
      if ($urandom_range(5) == 0) begin
        frag.push_back(CH_FOUR);
        frag.push_back(CH_ZERO);
      end else begin
        frag.push_back(CH_TWO);
        if ($urandom_range(1)) frag.push_back(8'(CH_ZERO + $urandom_range(7)));
        else frag.push_back(8'(CH_A + $urandom_range(4)));
      end
    end else if (pick < 75) begin
      frag.push_back(CH_PCT);
      case ($urandom_range(2))
        0: ;
        1: frag.push_back(CH_TWO);
        default: frag.push_back(CH_FOUR);
      endcase
      case ($urandom_range(3))
        0: frag.push_back(CH_PCT);
        1: frag.push_back(8'($urandom_range(8'h66, 8'h61)));  // lower case hex
        default: frag.push_back(8'($urandom_range(255)));
      endcase
    end else begin
      frag.push_back(8'($urandom_range(255)));
    end
    foreach (frag[k]) send_char(in_item_t'({frag[k], $urandom_range(11) == 0}), -1, '0);
  endtask

  // Check each taken result against the oldest due char
  always @(posedge clk) begin : watch_out
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_chars.size() == 0) begin
        $error("unexpected item: out_byte=%h out_last=%b", out_item.out_byte,
               out_item.out_last);
        n_fail++;
      end else begin
        want = due_chars.pop_front();
        if (out_item.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, out_item.out_byte);
          n_fail++;
        end
        if (out_item.out_last !== want.out_last) begin
          $error("out_last: expected %b, actual %b", want.out_last, out_item.out_last);
          n_fail++;
        end
      end
    end
  end

  initial begin : stimulus
    int phase_end;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_char(dir_rows[i].item, dir_rows[i].n_fixed, dir_rows[i].fixed);

    // Random phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      // Hold off until the decoder has drained
      if (ph == 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (due_chars.size() != 0);
      end
      phase_end = n_sent + RAND_ITEMS / 4;
      while (n_sent < phase_end) send_fragment();
    end

    in_valid <= 1'b0;
    while (due_chars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
